/* rtl/bmhq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, types and codes for the min-priority queue and its cell row.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Storage depth and value width of the queue.
    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [COUNT_W-1:0]            count_t;

    // Operation carried by each command item.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    // Outcome reported with each response item.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic   push_en;
        logic   pop_en;
        value_t value;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/binary_min_heap_queue_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Priority queue of signed values that reports the minimum after each item.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH signed values in a row of cells kept in
// ascending order, so the smallest value always sits in the first cell. Each
// command item is a push of push_value or a pop of the minimum. A pop shifts
// the whole row by one place, a push shifts the cells from its insertion point
// on, both in the cycle of acceptance, and the response item is valid from the
// next cycle. A new command is taken in every cycle in which the response
// register is empty or being taken. A push to a full queue or a pop from an
// empty one changes nothing and reports STATUS_FULL or STATUS_EMPTY. The cells
// need no clearing after reset; only slots below the entry count are used.
module binary_min_heap_queue_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire bmhq_pkg::opcode_t   opcode,
    input  wire bmhq_pkg::value_t    push_value,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output bmhq_pkg::value_t         min_value,
    output bmhq_pkg::count_t         entry_count,
    output logic                     is_empty,
    output bmhq_pkg::status_t        status
);
    import bmhq_pkg::*;

    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    count_t     count_reg;
    count_t     count_next;
    status_t    status_reg;
    status_t    status_next;
    logic       accept;
    logic       is_full;
    logic       held_none;
    cell_ctrl_t ctrl;
    value_t     cell_value [DEPTH];
    logic       cell_less  [DEPTH];

    // Handshake: a command waits only while a response is held up.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_full   = (count_reg == count_t'(DEPTH));
    assign held_none = (count_reg == '0);

    // Decode the command into the broadcast cell control.
    always_comb
    begin
        ctrl.push_en = accept && (opcode == OP_PUSH) && !is_full;
        ctrl.pop_en  = accept && (opcode == OP_POP) && !held_none;
        ctrl.value   = push_value;
    end

    // Next count, status and response valid.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = STATUS_OK;
            if (ctrl.push_en)
            begin
                count_next = count_reg + count_t'(1);
            end
            else if (ctrl.pop_en)
            begin
                count_next = count_reg - count_t'(1);
            end
            else if (opcode == OP_PUSH)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                status_next = STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= STATUS_OK;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
        end
    end

    // The sorted cell row.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam count_t IDX = count_t'(i);
        logic   left_less;
        value_t left_value;
        value_t right_value;

        if (i == 0)
        begin : g_first
            assign left_less  = 1'b0;
            assign left_value = '0;
        end
        else
        begin : g_inner_left
            assign left_less  = cell_less[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        bmhq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (IDX < count_reg),
            .left_less   (left_less),
            .left_value  (left_value),
            .right_value (right_value),
            .less        (cell_less[i]),
            .value       (cell_value[i])
        );
    end

    // Response fields come straight from the held state, which only moves
    // when the response is taken or absent.
    assign rsp_valid   = rsp_valid_reg;
    assign min_value   = held_none ? '0 : cell_value[0];
    assign entry_count = count_reg;
    assign is_empty    = held_none;
    assign status      = status_reg;

    // The count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(DEPTH))
        else $error("entry count above depth");

    // A stall on the command side only comes from a held response.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid_reg)
        else $error("command stalled without a pending response");

    // A refused push leaves the count alone and reports full.
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_PUSH) && is_full)
        |=> (status_reg == STATUS_FULL) && $stable(count_reg))
        else $error("push to a full queue was not refused");

    // The first two held values stay in order.
    a_row_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= count_t'(2)) |-> !(cell_value[1] < cell_value[0]))
        else $error("cell row out of order");

endmodule
`default_nettype wire

/* rtl/bmhq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_cell
// One slot of the sorted cell row. On a push the slot keeps its value, takes
// the new value, or takes its left neighbor's value; on a pop it takes its
// right neighbor's value.
// ----------------------------------------------------------------------------
module bmhq_cell (
    input  wire logic                clk,
    input  wire bmhq_pkg::cell_ctrl_t ctrl,
    input  wire logic                occupied,
    input  wire logic                left_less,
    input  wire bmhq_pkg::value_t    left_value,
    input  wire bmhq_pkg::value_t    right_value,
    output logic                     less,
    output bmhq_pkg::value_t         value
);
    import bmhq_pkg::*;

    value_t value_reg;
    value_t value_next;

    // An empty slot acts as plus infinity, so a push always lands in it.
    assign less = !occupied || (ctrl.value < value_reg);

    // Insert or shift according to this slot's and the left slot's compare.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.push_en)
        begin
            if (less)
            begin
                value_next = left_less ? left_value : ctrl.value;
            end
        end
        else if (ctrl.pop_en)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire
